// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL of the flat-bottom well block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("assertion failed");

// Checks that a condition is followed by another one in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/fbweg_pkg.sv -----
// Package with widths, register indexes and stage types of the flat-bottom well block.
`timescale 1ns / 1ps
package fbweg_pkg;

  localparam int COORD_W  = 20;
  localparam int MAG_W    = 20;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int S_W      = 42;
  localparam int D_W      = 21;
  localparam int K_W      = 24;
  localparam int M_W      = 23;
  localparam int KW_W     = 45;
  localparam int SLOPE_W  = 38;
  localparam int N_W      = 58;
  localparam int Q_W      = 39;
  localparam int E_W      = 48;
  localparam int G_W      = 40;
  localparam int SQ_STEPS = D_W;
  localparam int DV_STEPS = Q_W;
  localparam int IN_W     = 6 * COORD_W;
  localparam int OUT_W    = E_W + 3 * G_W;
  localparam int CFG_W    = K_W;
  localparam int ADDR_W   = 3;

  typedef enum logic [ADDR_W-1:0] {
    REG_OUTER_LOW      = 3'd0,
    REG_INNER_LOW      = 3'd1,
    REG_INNER_HIGH     = 3'd2,
    REG_OUTER_HIGH     = 3'd3,
    REG_STIFFNESS_LOW  = 3'd4,
    REG_STIFFNESS_HIGH = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            vneg;
  } vec_t;

  typedef struct packed {
    vec_t                 v;
    logic [2:0][SQ_W-1:0] sq;
  } sqr_t;

  typedef struct packed {
    vec_t           v;
    logic [S_W-1:0] s;
    logic [22:0]    rem;
    logic [D_W-1:0] root;
  } sqst_t;

  typedef struct packed {
    vec_t           v;
    logic [K_W-1:0] k;
    logic [D_W-1:0] w;
    logic [M_W-1:0] m;
    logic           neg_slope;
    logic           zero;
    logic           err;
    logic [D_W-1:0] d;
  } cls_t;

  typedef struct packed {
    vec_t            v;
    logic [KW_W-1:0] kw;
    logic [M_W-1:0]  m;
    logic            neg_slope;
    logic            zero;
    logic            err;
    logic [D_W-1:0]  d;
  } m1_t;

  typedef struct packed {
    vec_t               v;
    logic [45:0]        elo;
    logic [44:0]        ehi;
    logic [SLOPE_W-1:0] slope;
    logic               neg_slope;
    logic               zero;
    logic               err;
    logic [D_W-1:0]     d;
  } m2_t;

  typedef struct packed {
    logic [2:0]           vneg;
    logic [2:0][Q_W-1:0]  nlo;
    logic [2:0][Q_W-1:0]  nhi;
    logic [E_W-1:0]       energy;
    logic                 neg_slope;
    logic                 zero;
    logic                 err;
    logic [D_W-1:0]       d;
  } m3_t;

  typedef struct packed {
    logic [2:0]          vneg;
    logic [2:0][N_W-1:0] n;
    logic [E_W-1:0]      energy;
    logic                neg_slope;
    logic                zero;
    logic                err;
    logic [D_W-1:0]      d;
  } m4_t;

  typedef struct packed {
    logic [2:0]          vneg;
    logic [2:0][D_W-1:0] rem;
    logic [2:0][Q_W-1:0] n;
    logic [2:0][Q_W-1:0] q;
    logic [2:0]          sat;
    logic [E_W-1:0]      energy;
    logic                neg_slope;
    logic                zero;
    logic                err;
    logic [D_W-1:0]      d;
  } dvst_t;

endpackage

// ----- rtl/core/flat_bottom_well_energy_gradient.sv -----
// Top level of the flat-bottom well block: distance, well score and gradient pipeline.
`timescale 1ns / 1ps
// The block takes one pair of points per beat and returns one beat of score and gradient
// for it; it accepts a new pair in every cycle in which the output is not stalled.
// The pipeline holds the 21 square-root stages and the 39 gradient division stages, each
// resolving one result bit; a stall on the output halts the whole pipeline at once.
// Bounds and stiffnesses must only be written while no beat is in flight.
`include "assert_macros.svh"
module flat_bottom_well_energy_gradient (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fbweg_pkg::ADDR_W-1:0] cfg_addr_i,
  input  logic [fbweg_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z from the lowest bit up.
  input  logic [fbweg_pkg::IN_W-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // energy, grad_x, grad_y, grad_z from the lowest bit up.
  output logic [fbweg_pkg::OUT_W-1:0]  m_axis_tdata,
  // bounds_error.
  output logic                         m_axis_tuser
);
  import fbweg_pkg::*;

  logic [D_W-1:0] outer_low_q, inner_low_q, inner_high_q, outer_high_q;
  logic [K_W-1:0] stiff_low_q, stiff_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_low_q  <= '0;
      inner_low_q  <= '0;
      inner_high_q <= '0;
      outer_high_q <= '0;
      stiff_low_q  <= '0;
      stiff_high_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_OUTER_LOW:      outer_low_q  <= cfg_wdata_i[D_W-1:0];
        REG_INNER_LOW:      inner_low_q  <= cfg_wdata_i[D_W-1:0];
        REG_INNER_HIGH:     inner_high_q <= cfg_wdata_i[D_W-1:0];
        REG_OUTER_HIGH:     outer_high_q <= cfg_wdata_i[D_W-1:0];
        REG_STIFFNESS_LOW:  stiff_low_q  <= cfg_wdata_i;
        REG_STIFFNESS_HIGH: stiff_high_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  logic en;
  logic out_vld_q;
  assign en = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  // Stage 0: difference vector.
  vec_t p0_d, p0_q;
  logic p0_vld_q;
  always_comb begin
    p0_d = '0;
    for (int i = 0; i < 3; i++) begin
      logic signed [COORD_W:0] a, b, df;
      a  = {s_axis_tdata[i*COORD_W+COORD_W-1], s_axis_tdata[i*COORD_W +: COORD_W]};
      b  = {s_axis_tdata[(i+3)*COORD_W+COORD_W-1], s_axis_tdata[(i+3)*COORD_W +: COORD_W]};
      df = a - b;
      p0_d.vneg[i] = df[COORD_W];
      p0_d.mag[i]  = df[COORD_W] ? MAG_W'(-df) : MAG_W'(df);
    end
  end

  // Stage 1: squares.
  sqr_t p1_d, p1_q;
  logic p1_vld_q;
  always_comb begin
    p1_d.v = p0_q;
    for (int i = 0; i < 3; i++) begin
      p1_d.sq[i] = SQ_W'(p0_q.mag[i]) * SQ_W'(p0_q.mag[i]);
    end
  end

  // Stage 2 and the square-root stages.
  sqst_t sq_q [0:SQ_STEPS];
  logic  sq_vld_q [0:SQ_STEPS];
  sqst_t sq0_d;
  always_comb begin
    sq0_d.v    = p1_q.v;
    sq0_d.s    = S_W'(p1_q.sq[0]) + S_W'(p1_q.sq[1]) + S_W'(p1_q.sq[2]);
    sq0_d.rem  = '0;
    sq0_d.root = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld_q    <= 1'b0;
      p1_vld_q    <= 1'b0;
      sq_vld_q[0] <= 1'b0;
    end else if (en) begin
      p0_vld_q    <= s_axis_tvalid;
      p1_vld_q    <= p0_vld_q;
      sq_vld_q[0] <= p1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q     <= p0_d;
      p1_q     <= p1_d;
      sq_q[0]  <= sq0_d;
    end
  end

  for (genvar i = 1; i <= SQ_STEPS; i++) begin : g_sqrt
    localparam int B = SQ_STEPS - i;
    sqst_t st_d;
    always_comb begin
      logic [24:0] r, trial;
      r     = {sq_q[i-1].rem, sq_q[i-1].s[2*B+1 -: 2]};
      trial = {2'b00, sq_q[i-1].root, 2'b01};
      st_d  = sq_q[i-1];
      if (r >= trial) begin
        st_d.rem  = 23'(r - trial);
        st_d.root = {sq_q[i-1].root[D_W-2:0], 1'b1};
      end else begin
        st_d.rem  = 23'(r);
        st_d.root = {sq_q[i-1].root[D_W-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_vld_q[i] <= 1'b0;
      end else if (en) begin
        sq_vld_q[i] <= sq_vld_q[i-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        sq_q[i] <= st_d;
      end
    end
  end

  // Region selection.
  cls_t cl_d, cl_q;
  logic cl_vld_q;
  always_comb begin
    logic [D_W-1:0] d, e;
    d = sq_q[SQ_STEPS].root;
    e = '0;
    cl_d.v         = sq_q[SQ_STEPS].v;
    cl_d.d         = d;
    cl_d.err       = !(outer_low_q <= inner_low_q && inner_low_q <= inner_high_q &&
                       inner_high_q <= outer_high_q);
    cl_d.zero      = cl_d.err;
    cl_d.k         = stiff_high_q;
    cl_d.w         = '0;
    cl_d.neg_slope = 1'b0;
    priority if (d < outer_low_q) begin
      cl_d.k         = stiff_low_q;
      cl_d.w         = inner_low_q - outer_low_q;
      e              = outer_low_q - d;
      cl_d.neg_slope = 1'b1;
    end else if (d < inner_low_q) begin
      cl_d.k         = stiff_low_q;
      cl_d.w         = inner_low_q - d;
      cl_d.neg_slope = 1'b1;
    end else if (d <= inner_high_q) begin
      cl_d.zero      = 1'b1;
    end else if (d <= outer_high_q) begin
      cl_d.w         = d - inner_high_q;
    end else begin
      cl_d.w         = outer_high_q - inner_high_q;
      e              = d - outer_high_q;
    end
    cl_d.m = M_W'(cl_d.w) + {1'b0, e, 1'b0};
  end

  // Multiplier stages.
  m1_t m1_d, m1_q;
  m2_t m2_d, m2_q;
  m3_t m3_d, m3_q;
  m4_t m4_d, m4_q;
  logic m1_vld_q, m2_vld_q, m3_vld_q, m4_vld_q;

  always_comb begin
    m1_d.v         = cl_q.v;
    m1_d.kw        = KW_W'(cl_q.k) * KW_W'(cl_q.w);
    m1_d.m         = cl_q.m;
    m1_d.neg_slope = cl_q.neg_slope;
    m1_d.zero      = cl_q.zero;
    m1_d.err       = cl_q.err;
    m1_d.d         = cl_q.d;
  end

  always_comb begin
    m2_d.v         = m1_q.v;
    m2_d.elo       = 46'(m1_q.kw[22:0]) * 46'(m1_q.m);
    m2_d.ehi       = 45'(m1_q.kw[44:23]) * 45'(m1_q.m);
    m2_d.slope     = m1_q.kw[44:7];
    m2_d.neg_slope = m1_q.neg_slope;
    m2_d.zero      = m1_q.zero;
    m2_d.err       = m1_q.err;
    m2_d.d         = m1_q.d;
  end

  always_comb begin
    logic [67:0] prod;
    prod = {m2_q.ehi, 23'b0} + 68'(m2_q.elo);
    m3_d.energy    = (prod[67:64] != 4'b0) ? {E_W{1'b1}} : prod[63:16];
    m3_d.vneg      = m2_q.v.vneg;
    for (int i = 0; i < 3; i++) begin
      m3_d.nlo[i] = Q_W'(m2_q.slope[18:0]) * Q_W'(m2_q.v.mag[i]);
      m3_d.nhi[i] = Q_W'(m2_q.slope[37:19]) * Q_W'(m2_q.v.mag[i]);
    end
    m3_d.neg_slope = m2_q.neg_slope;
    m3_d.zero      = m2_q.zero;
    m3_d.err       = m2_q.err;
    m3_d.d         = m2_q.d;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      m4_d.n[i] = {m3_q.nhi[i], 19'b0} + N_W'(m3_q.nlo[i]);
    end
    m4_d.vneg      = m3_q.vneg;
    m4_d.energy    = m3_q.energy;
    m4_d.neg_slope = m3_q.neg_slope;
    m4_d.zero      = m3_q.zero;
    m4_d.err       = m3_q.err;
    m4_d.d         = m3_q.d;
  end

  // Divider set-up: a quotient that needs more than its width saturates.
  dvst_t dv_q [0:DV_STEPS];
  logic  dv_vld_q [0:DV_STEPS];
  dvst_t dv0_d;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv0_d.sat[i] = D_W'(m4_q.n[i][N_W-1:Q_W]) >= m4_q.d;
      dv0_d.rem[i] = D_W'(m4_q.n[i][N_W-1:Q_W]);
      dv0_d.n[i]   = m4_q.n[i][Q_W-1:0];
      dv0_d.q[i]   = '0;
    end
    dv0_d.vneg      = m4_q.vneg;
    dv0_d.energy    = m4_q.energy;
    dv0_d.neg_slope = m4_q.neg_slope;
    dv0_d.zero      = m4_q.zero;
    dv0_d.err       = m4_q.err;
    dv0_d.d         = m4_q.d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cl_vld_q    <= 1'b0;
      m1_vld_q    <= 1'b0;
      m2_vld_q    <= 1'b0;
      m3_vld_q    <= 1'b0;
      m4_vld_q    <= 1'b0;
      dv_vld_q[0] <= 1'b0;
    end else if (en) begin
      cl_vld_q    <= sq_vld_q[SQ_STEPS];
      m1_vld_q    <= cl_vld_q;
      m2_vld_q    <= m1_vld_q;
      m3_vld_q    <= m2_vld_q;
      m4_vld_q    <= m3_vld_q;
      dv_vld_q[0] <= m4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      cl_q     <= cl_d;
      m1_q     <= m1_d;
      m2_q     <= m2_d;
      m3_q     <= m3_d;
      m4_q     <= m4_d;
      dv_q[0]  <= dv0_d;
    end
  end

  for (genvar j = 1; j <= DV_STEPS; j++) begin : g_div
    localparam int B = DV_STEPS - j;
    dvst_t st_d;
    always_comb begin
      st_d = dv_q[j-1];
      for (int i = 0; i < 3; i++) begin
        logic [D_W:0] r;
        r = {dv_q[j-1].rem[i], dv_q[j-1].n[i][B]};
        if (r >= {1'b0, dv_q[j-1].d}) begin
          st_d.rem[i]  = D_W'(r - {1'b0, dv_q[j-1].d});
          st_d.q[i][B] = 1'b1;
        end else begin
          st_d.rem[i]  = r[D_W-1:0];
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j] <= 1'b0;
      end else if (en) begin
        dv_vld_q[j] <= dv_vld_q[j-1];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_q[j] <= st_d;
      end
    end
  end

  // Output register.
  logic [OUT_W-1:0] out_data_d, out_data_q;
  logic             out_err_q;
  always_comb begin
    dvst_t f;
    logic  no_grad;
    f = dv_q[DV_STEPS];
    no_grad = f.zero || (f.d == '0);
    out_data_d[E_W-1:0] = f.zero ? '0 : f.energy;
    for (int i = 0; i < 3; i++) begin
      logic [G_W-1:0] g;
      g = {1'b0, f.sat[i] ? {Q_W{1'b1}} : f.q[i]};
      if (no_grad) begin
        g = '0;
      end else if (f.vneg[i] != f.neg_slope) begin
        g = -g;
      end
      out_data_d[E_W + i*G_W +: G_W] = g;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld_q[DV_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= out_data_d;
      out_err_q  <= dv_q[DV_STEPS].err;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_err_q;

  `ASSERT_ALWAYS(a_err_zero, clk_i, rst_ni,
    !(out_vld_q && out_err_q) || (out_data_q == '0))
  `ASSERT_ALWAYS(a_sqrt_floor, clk_i, rst_ni,
    !sq_vld_q[SQ_STEPS] ||
    ((S_W'(sq_q[SQ_STEPS].root) * S_W'(sq_q[SQ_STEPS].root)) <= sq_q[SQ_STEPS].s))
  `ASSERT_ALWAYS(a_div_rem, clk_i, rst_ni,
    !(dv_vld_q[DV_STEPS] && !dv_q[DV_STEPS].sat[0]) ||
    (dv_q[DV_STEPS].rem[0] < dv_q[DV_STEPS].d))
  `ASSERT_NEXT(a_enter, clk_i, rst_ni, s_axis_tvalid && s_axis_tready, p0_vld_q)

endmodule
